### rtl/hsv2rgb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// Colour sector picked by the integer part of hue * 6
	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	// Division lanes: p, q and t each use the same divide-by-full-scale structure
	localparam int LANES  = 3;
	localparam int LANE_P = 0;
	localparam int LANE_Q = 1;
	localparam int LANE_T = 2;

endpackage
`default_nettype wire

### rtl/hsv2rgb_hsv_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_hsv_if
// Valid/ready channel carrying one HSV pixel with alpha.
// ----------------------------------------------------------------------------
interface hsv2rgb_hsv_if #(
	parameter int HUE_BITS       = 16,
	parameter int COMPONENT_BITS = 8
);
	logic                      valid;
	logic                      ready;
	logic [HUE_BITS-1:0]       hue;
	logic [COMPONENT_BITS-1:0] saturation;
	logic [COMPONENT_BITS-1:0] brightness;
	logic [COMPONENT_BITS-1:0] alpha_in;

	modport source (
		output valid, hue, saturation, brightness, alpha_in,
		input  ready
	);

	modport sink (
		input  valid, hue, saturation, brightness, alpha_in,
		output ready
	);
endinterface
`default_nettype wire

### rtl/hsv2rgb_rgb_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv2rgb_rgb_if
// Valid/ready channel carrying one RGB pixel with alpha.
// ----------------------------------------------------------------------------
interface hsv2rgb_rgb_if #(
	parameter int COMPONENT_BITS = 8
);
	logic                      valid;
	logic                      ready;
	logic [COMPONENT_BITS-1:0] red;
	logic [COMPONENT_BITS-1:0] green;
	logic [COMPONENT_BITS-1:0] blue;
	logic [COMPONENT_BITS-1:0] alpha_out;

	modport source (
		output valid, red, green, blue, alpha_out,
		input  ready
	);

	modport sink (
		input  valid, red, green, blue, alpha_out,
		output ready
	);
endinterface
`default_nettype wire

### rtl/hsv_to_rgb_converter_unit.sv
// An accepted input passes stages 1 to 4 before its result shows on rgb.
// Throughput: one pixel per cycle if rgb is ready; four register stages, each
// stage advances on its own, so bubbles close up while the output is stalled.
// Reset: arst_n clears the stage valid bits at once; payload is not reset.
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// Fixed-point HSV to RGB conversion with alpha pass-through, fully pipelined.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit #(
	parameter int COMPONENT_BITS = 8,
	parameter int HUE_BITS       = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	hsv2rgb_hsv_if.sink  hsv,
	hsv2rgb_rgb_if.source rgb
);

	localparam int C    = COMPONENT_BITS;
	localparam int HB   = HUE_BITS;
	localparam int W2   = 2 * C;       // v * component product
	localparam int W_SF = C + HB;      // s * fraction product
	localparam int W_PR = 2 * C + HB;  // v * (den - s * fraction)

	// Full scale M = 2^C - 1 and the derived rounding constants
	localparam logic [C-1:0]    FULL       = '1;
	localparam logic [W_SF-1:0] DEN        = {FULL, {HB{1'b0}}};
	localparam logic [W_PR-1:0] HALF_Q     = W_PR'({FULL, {(HB - 1){1'b0}}});
	localparam logic [W2-1:0]   HALF_P     = W2'(FULL >> 1);
	localparam logic [W2-1:0]   FULL_W     = W2'(FULL);
	localparam logic [W2-1:0]   TWICE_FULL = W2'({FULL, 1'b0});

	// ------------------------------------------------------------------
	// Stage enables: a stage loads when it is empty or its content moves on
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4 = !valid_s4 || rgb.ready;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign hsv.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= hsv.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: hue * 6 split into sector and fraction; first products
	// ------------------------------------------------------------------
	logic [HB+2:0] scaled;
	logic [HB-1:0] frac;
	logic [HB:0]   frac_cmp;
	logic [W_SF:0] stf_wide;
	logic [W_SF-1:0] sff;
	logic [W2-1:0]   pnum;

	// hue * 6 as hue * 4 + hue * 2; the three top bits are the sector
	assign scaled   = ({3'b000, hsv.hue} << 2) + ({3'b000, hsv.hue} << 1);
	assign frac     = scaled[HB-1:0];
	// 1 - fraction, one turn of the fraction being 2^HB
	assign frac_cmp = {1'b1, {HB{1'b0}}} - {1'b0, frac};
	assign sff      = W_SF'(hsv.saturation) * W_SF'(frac);
	assign stf_wide = (W_SF + 1)'(hsv.saturation) * (W_SF + 1)'(frac_cmp);
	assign pnum     = W2'(hsv.brightness) * W2'(FULL - hsv.saturation);

	hsv2rgb_pkg::sector_t sector_s1;
	logic [C-1:0]    v_s1;
	logic [C-1:0]    a_s1;
	logic [W2-1:0]   pnum_s1;
	logic [W_SF-1:0] sff_s1;
	logic [W_SF-1:0] stf_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sector_s1 <= hsv2rgb_pkg::sector_t'(scaled[HB+2:HB]);
			v_s1      <= hsv.brightness;
			a_s1      <= hsv.alpha_in;
			pnum_s1   <= pnum;
			sff_s1    <= sff;
			// s * (1 - ff) never exceeds M * 2^HB, so the top bit is zero
			stf_s1    <= stf_wide[W_SF-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: scale by v; round p's numerator
	// ------------------------------------------------------------------
	hsv2rgb_pkg::sector_t sector_s2;
	logic [C-1:0]    v_s2;
	logic [C-1:0]    a_s2;
	logic [W2-1:0]   py_s2;
	logic [W_PR-1:0] qprod_s2;
	logic [W_PR-1:0] tprod_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sector_s2 <= sector_s1;
			v_s2      <= v_s1;
			a_s2      <= a_s1;
			py_s2     <= pnum_s1 + HALF_P;
			qprod_s2  <= W_PR'(v_s1) * W_PR'(DEN - sff_s1);
			tprod_s2  <= W_PR'(v_s1) * W_PR'(DEN - stf_s1);
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: round q and t, drop the fraction scale (exact power of two),
	// then estimate the quotient by M as (y + y / 2^C) / 2^C. The estimate
	// falls short of the true quotient by at most one.
	// ------------------------------------------------------------------
	logic [W_PR-1:0] qsum, tsum;
	logic [W2-1:0]   y_nx  [hsv2rgb_pkg::LANES];
	logic [W2:0]     est_sum [hsv2rgb_pkg::LANES];
	logic [C-1:0]    est_nx [hsv2rgb_pkg::LANES];

	assign qsum = qprod_s2 + HALF_Q;
	assign tsum = tprod_s2 + HALF_Q;
	assign y_nx[hsv2rgb_pkg::LANE_P] = py_s2;
	// the rounded product over 2^HB stays below 2^W2
	assign y_nx[hsv2rgb_pkg::LANE_Q] = qsum[HB+W2-1:HB];
	assign y_nx[hsv2rgb_pkg::LANE_T] = tsum[HB+W2-1:HB];

	for (genvar i = 0; i < hsv2rgb_pkg::LANES; i++) begin : g_est
		assign est_sum[i] = (W2 + 1)'(y_nx[i]) + (W2 + 1)'(y_nx[i] >> C);
		// quotient never exceeds M, so C bits hold it
		assign est_nx[i]  = est_sum[i][W2-1:C];
	end

	hsv2rgb_pkg::sector_t sector_s3;
	logic [C-1:0]  v_s3;
	logic [C-1:0]  a_s3;
	logic [W2-1:0] y_s3   [hsv2rgb_pkg::LANES];
	logic [C-1:0]  est_s3 [hsv2rgb_pkg::LANES];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			sector_s3 <= sector_s2;
			v_s3      <= v_s2;
			a_s3      <= a_s2;
			for (int i = 0; i < hsv2rgb_pkg::LANES; i++) begin
				y_s3[i]   <= y_nx[i];
				est_s3[i] <= est_nx[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: correct the estimate with one remainder compare, route the
	// components by sector and hold them in the output register
	// ------------------------------------------------------------------
	logic [W2-1:0] rem  [hsv2rgb_pkg::LANES];
	logic [C-1:0]  quot [hsv2rgb_pkg::LANES];

	for (genvar i = 0; i < hsv2rgb_pkg::LANES; i++) begin : g_fix
		// y - est * M, with est * M = est * 2^C - est
		assign rem[i]  = y_s3[i] - {est_s3[i], {C{1'b0}}} + W2'(est_s3[i]);
		assign quot[i] = est_s3[i] + C'(rem[i] >= FULL_W);
	end

	logic [C-1:0] p_c, q_c, t_c;
	logic [C-1:0] red_nx, green_nx, blue_nx;

	assign p_c = quot[hsv2rgb_pkg::LANE_P];
	assign q_c = quot[hsv2rgb_pkg::LANE_Q];
	assign t_c = quot[hsv2rgb_pkg::LANE_T];

	// Zero saturation needs no special path: p, q and t all round to v.
	always_comb begin
		case (sector_s3)
			hsv2rgb_pkg::SEC_RED: begin
				red_nx = v_s3; green_nx = t_c; blue_nx = p_c;
			end
			hsv2rgb_pkg::SEC_YELLOW: begin
				red_nx = q_c; green_nx = v_s3; blue_nx = p_c;
			end
			hsv2rgb_pkg::SEC_GREEN: begin
				red_nx = p_c; green_nx = v_s3; blue_nx = t_c;
			end
			hsv2rgb_pkg::SEC_CYAN: begin
				red_nx = p_c; green_nx = q_c; blue_nx = v_s3;
			end
			hsv2rgb_pkg::SEC_BLUE: begin
				red_nx = t_c; green_nx = p_c; blue_nx = v_s3;
			end
			default: begin
				red_nx = v_s3; green_nx = p_c; blue_nx = q_c;
			end
		endcase
	end

	logic [C-1:0] red_s4, green_s4, blue_s4, a_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			red_s4   <= red_nx;
			green_s4 <= green_nx;
			blue_s4  <= blue_nx;
			a_s4     <= a_s3;
		end
	end

	assign rgb.valid     = valid_s4;
	assign rgb.red       = red_s4;
	assign rgb.green     = green_s4;
	assign rgb.blue      = blue_s4;
	assign rgb.alpha_out = a_s4;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// The quotient estimate is never more than one short
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (rem[hsv2rgb_pkg::LANE_P] < TWICE_FULL) &&
			(rem[hsv2rgb_pkg::LANE_Q] < TWICE_FULL) &&
			(rem[hsv2rgb_pkg::LANE_T] < TWICE_FULL))
		else $error("quotient estimate off by more than one");

	// No component ever exceeds the brightness
	a_below_v: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (p_c <= v_s3) && (q_c <= v_s3) && (t_c <= v_s3))
		else $error("component above brightness");

	// An accepted transaction occupies stage 1 in the next cycle
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid && hsv.ready |=> valid_s1)
		else $error("accepted pixel lost at stage 1");

	// A stage 3 item that advances reaches the output register
	a_reach_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && en_s4 |=> valid_s4)
		else $error("pixel lost between stage 3 and output");

	// A held result is not overwritten while the sink stalls
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !rgb.ready |=> valid_s4 && $stable(red_s4) && $stable(a_s4))
		else $error("stalled result changed");

endmodule
`default_nettype wire
